[src/fjcp_pkg.sv]
`timescale 1ns / 1ps

package fjcp_pkg;

   // Input transaction: one body byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] slot;
      logic [7:0] out_byte;
      logic       is_command;
      logic [2:0] status;
      logic       last_of_run;
   } rsp_type;

   // Result kinds
   localparam logic [1:0] KIND_KEY    = 2'd0;
   localparam logic [1:0] KIND_VALUE  = 2'd1;
   localparam logic [1:0] KIND_PAIR   = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   // Final status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_MALFORMED = 3'd1;
   localparam logic [2:0] ST_INVALID   = 3'd2;
   localparam logic [2:0] ST_NO_CMD    = 3'd3;
   localparam logic [2:0] ST_TOO_LARGE = 3'd4;

   // Parse outcome; an error code doubles as its status code
   typedef enum logic [2:0] {
      OC_PENDING   = 3'd0,
      OC_MALFORMED = 3'd1,
      OC_INVALID   = 3'd2,
      OC_TOO_LARGE = 3'd4,
      OC_DONE      = 3'd7
   } outcome_type;

   // Parser phase, one-hot
   typedef enum logic [8:0] {
      PH_OPEN         = 9'b000000001,
      PH_KEY_OR_END   = 9'b000000010,
      PH_KEY_STR      = 9'b000000100,
      PH_KEY_ESC      = 9'b000001000,
      PH_COLON        = 9'b000010000,
      PH_VAL_START    = 9'b000100000,
      PH_VAL_STR      = 9'b001000000,
      PH_VAL_ESC      = 9'b010000000,
      PH_COMMA_OR_END = 9'b100000000
   } phase_type;

   // Characters
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_R      = 8'h72;

   // Length of the key "command"
   localparam logic [2:0] CMD_WORD_LEN = 3'd7;

   function automatic logic [7:0] cmd_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h63;  // c
         3'd1:    ch = 8'h6F;  // o
         3'd2:    ch = 8'h6D;  // m
         3'd3:    ch = 8'h6D;  // m
         3'd4:    ch = 8'h61;  // a
         3'd5:    ch = 8'h6E;  // n
         3'd6:    ch = 8'h64;  // d
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] ch);
      logic [7:0] res;
      case (ch)
         CH_N:    res = CH_LF;
         CH_T:    res = CH_TAB;
         CH_R:    res = CH_CR;
         default: res = ch;
      endcase
      return res;
   endfunction

endpackage

[src/flat_json_command_parser_top.sv]
`timescale 1ns / 1ps
// A result is queued as its byte is taken; if the queue was empty, rsp_ offers it the cycle after.
// Throughput: one byte per cycle while rsp_stall is low and each byte gives at most one
// result; a closing byte may give two, and the four-entry result queue absorbs the extra transaction.
// req_stall rises only when fewer than two queue entries are free.
// Reset (synchronous, active high) returns the parser to "expect opening brace" and empties the queue.

module flat_json_command_parser_top #(
   parameter int MAX_BODY   = 512,
   parameter int MAX_VALUE  = 64,
   parameter int MAX_FIELDS = 8,
   parameter int KEY_LEN    = 32,
   parameter int VALUE_LEN  = 64,
   parameter int VERB_LEN   = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fjcp_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fjcp_pkg::rsp_type   rsp_data
);

   // Counter widths
   localparam int BC_W   = $clog2(MAX_BODY + 1);
   localparam int SLEN_W = $clog2(MAX_VALUE);
   localparam int FC_W   = $clog2(MAX_FIELDS + 1);

   localparam logic [BC_W-1:0]   BODY_MAX  = BC_W'(MAX_BODY);
   localparam logic [SLEN_W-1:0] STR_LIMIT = SLEN_W'(MAX_VALUE - 2);
   localparam logic [FC_W-1:0]   FIELDS    = FC_W'(MAX_FIELDS);
   localparam logic [7:0]        KEY_LIM   = 8'(KEY_LEN - 1);
   localparam logic [7:0]        VAL_LIM   = 8'(VALUE_LEN - 1);
   localparam logic [7:0]        VERB_LIM  = 8'(VERB_LEN - 1);

   // Result queue: four entries, up to two written per cycle
   localparam int QDEPTH = 4;
   localparam int QP_W   = $clog2(QDEPTH);

   // ---------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------
   fjcp_pkg::phase_type   phase_ff, phase_in;
   fjcp_pkg::outcome_type outcome_ff, outcome_in;
   logic [SLEN_W-1:0]     str_len_ff, str_len_in;
   logic [2:0]            cmd_match_ff, cmd_match_in;
   logic [FC_W-1:0]       field_cnt_ff, field_cnt_in;
   logic                  found_cmd_ff, found_cmd_in;
   logic                  verb_nonempty_ff, verb_nonempty_in;
   logic                  pair_is_cmd_ff, pair_is_cmd_in;
   logic [BC_W-1:0]       byte_cnt_ff, byte_cnt_in;
   logic                  overlong_ff, overlong_in;

   // Result queue
   fjcp_pkg::rsp_type     queue_ff [QDEPTH];
   logic [QP_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QP_W:0]         count_ff, count_in;

   logic                  req_take;
   logic                  rsp_take;
   logic [7:0]            ch;
   logic                  is_ws;
   logic                  fields_full;
   logic                  do_key;
   logic                  do_val;
   logic [7:0]            dchar;
   logic [7:0]            idx8;
   logic [7:0]            val_lim;
   logic                  tok_vld;
   fjcp_pkg::rsp_type     tok_rsp;
   logic                  stat_vld;
   fjcp_pkg::rsp_type     stat_rsp;
   logic [2:0]            status;
   logic [1:0]            push;
   fjcp_pkg::rsp_type     first_rsp;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   assign ch          = req_data.data_byte;
   assign is_ws       = ch inside {fjcp_pkg::CH_SPACE, fjcp_pkg::CH_TAB,
                                   fjcp_pkg::CH_CR, fjcp_pkg::CH_LF};
   assign fields_full = (field_cnt_ff >= FIELDS);
   assign idx8        = 8'(str_len_ff);
   assign val_lim     = pair_is_cmd_ff ? VERB_LIM : VAL_LIM;
   // Escaped characters are decoded; plain ones pass untouched
   assign dchar       = (phase_ff == fjcp_pkg::PH_KEY_ESC || phase_ff == fjcp_pkg::PH_VAL_ESC)
                        ? fjcp_pkg::unescape(ch) : ch;

   // ---------------------------------------------------------------
   // Next state and the results of the byte being taken
   // ---------------------------------------------------------------
   always_comb begin
      phase_in         = phase_ff;
      outcome_in       = outcome_ff;
      str_len_in       = str_len_ff;
      cmd_match_in     = cmd_match_ff;
      field_cnt_in     = field_cnt_ff;
      found_cmd_in     = found_cmd_ff;
      verb_nonempty_in = verb_nonempty_ff;
      pair_is_cmd_in   = pair_is_cmd_ff;
      byte_cnt_in      = byte_cnt_ff;
      overlong_in      = overlong_ff;
      do_key           = 1'b0;
      do_val           = 1'b0;
      tok_vld          = 1'b0;
      tok_rsp          = '0;
      stat_vld         = 1'b0;
      stat_rsp         = '0;
      status           = fjcp_pkg::ST_OK;

      if (req_take) begin
         // Body length guard; parsing carries on regardless
         if (byte_cnt_ff >= BODY_MAX) begin
            overlong_in = 1'b1;
         end else begin
            byte_cnt_in = byte_cnt_ff + 1'b1;
         end

         if (outcome_ff == fjcp_pkg::OC_PENDING) begin
            case (phase_ff)
               fjcp_pkg::PH_OPEN: begin
                  if (!is_ws) begin
                     if (ch == fjcp_pkg::CH_LBRACE) phase_in = fjcp_pkg::PH_KEY_OR_END;
                     else outcome_in = fjcp_pkg::OC_MALFORMED;
                  end
               end
               fjcp_pkg::PH_KEY_OR_END: begin
                  if (!is_ws) begin
                     if (ch == fjcp_pkg::CH_RBRACE) begin
                        outcome_in = fjcp_pkg::OC_DONE;
                     end else if (ch == fjcp_pkg::CH_QUOTE) begin
                        str_len_in   = '0;
                        cmd_match_in = '0;
                        phase_in     = fjcp_pkg::PH_KEY_STR;
                     end else begin
                        outcome_in = fjcp_pkg::OC_MALFORMED;
                     end
                  end
               end
               fjcp_pkg::PH_KEY_STR: begin
                  if (ch == fjcp_pkg::CH_QUOTE) begin
                     pair_is_cmd_in = (cmd_match_ff == fjcp_pkg::CMD_WORD_LEN) &&
                                      (idx8 == 8'(fjcp_pkg::CMD_WORD_LEN));
                     phase_in = fjcp_pkg::PH_COLON;
                  end else if (ch == fjcp_pkg::CH_BSLASH) begin
                     phase_in = fjcp_pkg::PH_KEY_ESC;
                  end else begin
                     do_key = 1'b1;
                  end
               end
               fjcp_pkg::PH_KEY_ESC: begin
                  do_key   = 1'b1;
                  phase_in = fjcp_pkg::PH_KEY_STR;
               end
               fjcp_pkg::PH_COLON: begin
                  if (!is_ws) begin
                     if (ch == fjcp_pkg::CH_COLON) phase_in = fjcp_pkg::PH_VAL_START;
                     else outcome_in = fjcp_pkg::OC_MALFORMED;
                  end
               end
               fjcp_pkg::PH_VAL_START: begin
                  if (!is_ws) begin
                     if (ch == fjcp_pkg::CH_QUOTE) begin
                        str_len_in = '0;
                        phase_in   = fjcp_pkg::PH_VAL_STR;
                     end else begin
                        outcome_in = fjcp_pkg::OC_INVALID;
                     end
                  end
               end
               fjcp_pkg::PH_VAL_STR: begin
                  if (ch == fjcp_pkg::CH_QUOTE) begin
                     if (pair_is_cmd_ff) begin
                        found_cmd_in       = 1'b1;
                        verb_nonempty_in   = (str_len_ff != '0);
                        tok_vld            = 1'b1;
                        tok_rsp.kind       = fjcp_pkg::KIND_PAIR;
                        tok_rsp.is_command = 1'b1;
                     end else if (fields_full) begin
                        outcome_in = fjcp_pkg::OC_TOO_LARGE;
                     end else begin
                        tok_vld      = 1'b1;
                        tok_rsp.kind = fjcp_pkg::KIND_PAIR;
                        tok_rsp.slot = 3'(field_cnt_ff);
                        field_cnt_in = field_cnt_ff + 1'b1;
                     end
                     phase_in = fjcp_pkg::PH_COMMA_OR_END;
                  end else if (ch == fjcp_pkg::CH_BSLASH) begin
                     phase_in = fjcp_pkg::PH_VAL_ESC;
                  end else begin
                     do_val = 1'b1;
                  end
               end
               fjcp_pkg::PH_VAL_ESC: begin
                  do_val   = 1'b1;
                  phase_in = fjcp_pkg::PH_VAL_STR;
               end
               fjcp_pkg::PH_COMMA_OR_END: begin
                  if (!is_ws) begin
                     if (ch == fjcp_pkg::CH_COMMA) phase_in = fjcp_pkg::PH_KEY_OR_END;
                     else if (ch == fjcp_pkg::CH_RBRACE) outcome_in = fjcp_pkg::OC_DONE;
                     else outcome_in = fjcp_pkg::OC_MALFORMED;
                  end
               end
               default: begin
                  outcome_in = fjcp_pkg::OC_MALFORMED;
               end
            endcase

            // Key character
            if (do_key) begin
               str_len_in = str_len_ff + 1'b1;
               if (str_len_ff >= STR_LIMIT) begin
                  outcome_in = fjcp_pkg::OC_MALFORMED;
               end else begin
                  if ((8'(cmd_match_ff) == idx8) && (idx8 < 8'(fjcp_pkg::CMD_WORD_LEN)) &&
                      (dchar == fjcp_pkg::cmd_char(idx8[2:0]))) begin
                     cmd_match_in = cmd_match_ff + 1'b1;
                  end
                  if (idx8 < KEY_LIM && !fields_full) begin
                     tok_vld          = 1'b1;
                     tok_rsp.kind     = fjcp_pkg::KIND_KEY;
                     tok_rsp.slot     = 3'(field_cnt_ff);
                     tok_rsp.out_byte = dchar;
                  end
               end
            end

            // Value character
            if (do_val) begin
               str_len_in = str_len_ff + 1'b1;
               if (str_len_ff >= STR_LIMIT) begin
                  outcome_in = fjcp_pkg::OC_INVALID;
               end else if (idx8 < val_lim && (pair_is_cmd_ff || !fields_full)) begin
                  tok_vld            = 1'b1;
                  tok_rsp.kind       = fjcp_pkg::KIND_VALUE;
                  tok_rsp.slot       = pair_is_cmd_ff ? 3'd0 : 3'(field_cnt_ff);
                  tok_rsp.out_byte   = dchar;
                  tok_rsp.is_command = pair_is_cmd_ff;
               end
            end
         end

         // Closing byte: status, then back to the reset state
         if (req_data.is_last) begin
            if (overlong_in) begin
               status = fjcp_pkg::ST_TOO_LARGE;
            end else if (outcome_in == fjcp_pkg::OC_DONE) begin
               status = (found_cmd_in && verb_nonempty_in) ? fjcp_pkg::ST_OK
                                                           : fjcp_pkg::ST_NO_CMD;
            end else if (outcome_in != fjcp_pkg::OC_PENDING) begin
               status = 3'(outcome_in);
            end else if (phase_in == fjcp_pkg::PH_VAL_START ||
                         phase_in == fjcp_pkg::PH_VAL_STR ||
                         phase_in == fjcp_pkg::PH_VAL_ESC) begin
               status = fjcp_pkg::ST_INVALID;
            end else begin
               status = fjcp_pkg::ST_MALFORMED;
            end
            stat_vld         = 1'b1;
            stat_rsp.kind    = fjcp_pkg::KIND_STATUS;
            stat_rsp.status  = status;

            phase_in         = fjcp_pkg::PH_OPEN;
            outcome_in       = fjcp_pkg::OC_PENDING;
            str_len_in       = '0;
            cmd_match_in     = '0;
            field_cnt_in     = '0;
            found_cmd_in     = 1'b0;
            verb_nonempty_in = 1'b0;
            pair_is_cmd_in   = 1'b0;
            byte_cnt_in      = '0;
            overlong_in      = 1'b0;
         end
      end

      // The status always ends the run; otherwise the token does
      stat_rsp.last_of_run = 1'b1;
      tok_rsp.last_of_run  = !stat_vld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= fjcp_pkg::PH_OPEN;
         outcome_ff       <= fjcp_pkg::OC_PENDING;
         str_len_ff       <= '0;
         cmd_match_ff     <= '0;
         field_cnt_ff     <= '0;
         found_cmd_ff     <= 1'b0;
         verb_nonempty_ff <= 1'b0;
         pair_is_cmd_ff   <= 1'b0;
         byte_cnt_ff      <= '0;
         overlong_ff      <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         outcome_ff       <= outcome_in;
         str_len_ff       <= str_len_in;
         cmd_match_ff     <= cmd_match_in;
         field_cnt_ff     <= field_cnt_in;
         found_cmd_ff     <= found_cmd_in;
         verb_nonempty_ff <= verb_nonempty_in;
         pair_is_cmd_ff   <= pair_is_cmd_in;
         byte_cnt_ff      <= byte_cnt_in;
         overlong_ff      <= overlong_in;
      end
   end

   // ---------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------
   assign push      = 2'(tok_vld) + 2'(stat_vld);
   assign first_rsp = tok_vld ? tok_rsp : stat_rsp;

   // Stall unless two entries are free, so a closing byte always fits
   assign req_stall = (count_ff > (QP_W+1)'(QDEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + QP_W'(push);
   assign rd_ptr_in = rd_ptr_ff + QP_W'(rsp_take);
   assign count_in  = count_ff + (QP_W+1)'(push) - (QP_W+1)'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_rsp;
      end
      if (push == 2'd2) begin
         queue_ff[wr_ptr_ff + 1'b1] <= stat_rsp;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];

endmodule

[src/fjcp_checker.sv]
`timescale 1ns / 1ps

module fjcp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input fjcp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input fjcp_pkg::rsp_type rsp_data
);

   // A stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Reset empties the queue and opens the input side
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not empty after reset");

   // A status transaction ends its run and carries a known code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == fjcp_pkg::KIND_STATUS |->
         rsp_data.last_of_run && rsp_data.status <= fjcp_pkg::ST_TOO_LARGE)
      else $error("bad status transaction");

   // Only status transactions carry a status; key bytes never belong to the verb
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != fjcp_pkg::KIND_STATUS |->
         rsp_data.status == fjcp_pkg::ST_OK &&
         !(rsp_data.kind == fjcp_pkg::KIND_KEY && rsp_data.is_command))
      else $error("bad token transaction");

endmodule

bind flat_json_command_parser_top fjcp_checker u_fjcp_checker (.*);
